### hdl/uer_pkg.sv
// shared types, register map and constants for the echo ranger
package uer_pkg;

  // measurement cycle phases
  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COUNT   = 2'd2,
    PH_GAP     = 2'd3
  } phase_t;

  // per-tick flags handed from the front end to the back end
  typedef struct packed {
    logic trigger;
    logic done;
    logic overflow;
  } tick_flags_t;

  // one result beat
  typedef struct packed {
    logic        trigger;
    logic        done_res;
    logic        out_of_range;
    logic [10:0] distance_cm;
    logic [15:0] pulse_ticks;
    logic [3:0]  digit_metres;
    logic [3:0]  digit_decimetres;
    logic [3:0]  digit_centimetres;
  } result_t;

  // register map, index is paddr[3:2]
  localparam int         REG_AW            = 4;
  localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [1:0] REG_GAP_TICKS     = 2'd1;
  localparam logic [1:0] REG_MAX_RANGE     = 2'd2;

  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd21;
  localparam logic [19:0] GAP_TICKS_RST     = 20'd73728;
  localparam logic [10:0] MAX_RANGE_RST     = 11'd700;

  // distance = floor(ticks * 17 / 1000), the divide done by reciprocal
  localparam int          DIV_DIVISOR = 1000;
  localparam int          DIV_SHIFT   = 32;
  localparam int          RECIP_W     = 23;
  localparam logic [22:0] DIV_RECIP   = 23'd4294967;
  localparam logic [10:0] DIST_SAT    = 11'd2047;

  // hundreds digit of a value below 1000
  function automatic logic [3:0] hundreds_of(input logic [9:0] val);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (val >= 10'(k * 100)) d = 4'(k);
    end
    return d;
  endfunction

  // tens digit of a value below 100
  function automatic logic [3:0] tens_of(input logic [6:0] val);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (val >= 7'(k * 10)) d = 4'(k);
    end
    return d;
  endfunction

endpackage

### hdl/uer_queue.sv
// small register-based first-in first-out queue
module uer_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr_ok, rd_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_ok   = wr_en & ~full;
  assign rd_ok   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(wr_ok) - CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/uer_front.sv
// front end: phase sequencer that classifies each tick
module uer_front #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    echo,
  input  logic [7:0]              trigger_ticks,
  input  logic [19:0]             gap_ticks,
  output uer_pkg::tick_flags_t    tick_flags,
  output logic [COUNTER_BITS-1:0] tick_pulse
);

  import uer_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] count_r, count_nxt, count_inc;
  logic                    ovf_r, ovf_nxt;
  logic [19:0]             timer_r, timer_nxt, timer_inc;
  logic [7:0]              trig_len;

  assign timer_inc = timer_r + 20'd1;
  assign count_inc = count_r + COUNTER_BITS'(1);
  assign trig_len  = (trigger_ticks == '0) ? 8'd1 : trigger_ticks;

  // state register, advanced only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIGGER;
      count_r <= '0;
      ovf_r   <= 1'b0;
      timer_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      timer_r <= timer_nxt;
    end
  end

  // next phase and tick classification
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    timer_nxt  = timer_r;
    tick_flags = '0;
    tick_pulse = '0;
    unique case (phase_r)
      PH_TRIGGER: begin
        tick_flags.trigger = 1'b1;
        timer_nxt          = timer_inc;
        if (timer_inc >= {12'd0, trig_len}) begin
          timer_nxt = '0;
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // first high tick already counts
        if (echo) begin
          count_nxt = count_inc;
          if (count_inc == '0) ovf_nxt = 1'b1;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          count_nxt = count_inc;
          if (count_inc == '0) ovf_nxt = 1'b1;
        end else begin
          tick_flags.done     = 1'b1;
          tick_flags.overflow = ovf_r;
          tick_pulse          = count_r;
          count_nxt           = '0;
          ovf_nxt             = 1'b0;
          timer_nxt           = '0;
          phase_nxt           = (gap_ticks == '0) ? PH_TRIGGER : PH_GAP;
        end
      end
      PH_GAP: begin
        timer_nxt = timer_inc;
        if (timer_inc >= gap_ticks) begin
          timer_nxt = '0;
          phase_nxt = PH_TRIGGER;
        end
      end
      default: begin
        phase_nxt = PH_TRIGGER;
      end
    endcase
  end

endmodule

### hdl/uer_back.sv
// back end: distance scaling, range check, digit split and result queue
module uer_back #(
  parameter int COUNTER_BITS = 16,
  parameter int OUT_DEPTH    = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tick_valid,
  output logic                    tick_ready,
  input  uer_pkg::tick_flags_t    tick_flags,
  input  logic [COUNTER_BITS-1:0] tick_pulse,
  input  logic [10:0]             max_range_cm,
  input  logic                    out_pop,
  output logic                    out_empty,
  output uer_pkg::result_t        out_res
);

  import uer_pkg::*;

  localparam int XW = COUNTER_BITS + 5;
  localparam int PW = XW + RECIP_W;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  // credits for free result queue slots
  logic [CW-1:0] credits_r, credits_nxt;
  logic          pop_ok;

  // stage registers
  logic          v1_r, v2_r, v3_r, v4_r;
  tick_flags_t   f1_r, f2_r, f3_r;
  logic [15:0]   p1_r, p2_r, p3_r;
  logic [XW-1:0] x1_r, x2_r;
  logic [PW-1:0] prod2_r;
  logic [10:0]   dist3_r;
  logic          oor3_r;
  result_t       res4_r;

  // stage one, three and four combinational terms
  logic [XW-1:0] x_in, q_x, rem, q_fix;
  logic [10:0]   dist_cm;
  logic [9:0]    r1;
  logic [6:0]    r2;
  logic [3:0]    dig_m, dig_d, dig_c;
  logic          show_digits;

  assign pop_ok     = out_pop & ~out_empty;
  assign tick_ready = tick_valid & (credits_r != '0);

  always_comb begin
    credits_nxt = credits_r - CW'(tick_ready) + CW'(pop_ok);
  end

  // ticks * 17 as shift and add
  assign x_in = (XW'(tick_pulse) << 4) + XW'(tick_pulse);

  // reciprocal quotient, then one correction step
  always_comb begin
    q_x     = XW'(prod2_r[PW-1:DIV_SHIFT]);
    rem     = x2_r - q_x * XW'(DIV_DIVISOR);
    q_fix   = (rem >= XW'(DIV_DIVISOR)) ? q_x + XW'(1) : q_x;
    dist_cm = (q_fix > XW'(DIST_SAT)) ? DIST_SAT : q_fix[10:0];
  end

  // decimal digit split
  always_comb begin
    if (dist3_r >= 11'd2000) begin
      r1 = 10'(dist3_r - 11'd2000);
    end else if (dist3_r >= 11'd1000) begin
      r1 = 10'(dist3_r - 11'd1000);
    end else begin
      r1 = dist3_r[9:0];
    end
    dig_m       = hundreds_of(r1);
    r2          = 7'(r1 - 10'(dig_m) * 10'd100);
    dig_d       = tens_of(r2);
    dig_c       = 4'(r2 - 7'(dig_d) * 7'd10);
    show_digits = f3_r.done & ~oor3_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credits_r <= CW'(OUT_DEPTH);
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
    end else begin
      credits_r <= credits_nxt;
      v1_r      <= tick_ready;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    f1_r    <= tick_flags;
    p1_r    <= 16'(tick_pulse);
    x1_r    <= x_in;

    f2_r    <= f1_r;
    p2_r    <= p1_r;
    x2_r    <= x1_r;
    prod2_r <= PW'(x1_r) * PW'(DIV_RECIP);

    f3_r    <= f2_r;
    p3_r    <= p2_r;
    dist3_r <= dist_cm;
    oor3_r  <= f2_r.done & (f2_r.overflow | (dist_cm >= max_range_cm));

    res4_r.trigger           <= f3_r.trigger;
    res4_r.done_res          <= f3_r.done;
    res4_r.out_of_range      <= oor3_r;
    res4_r.distance_cm       <= dist3_r;
    res4_r.pulse_ticks       <= p3_r;
    res4_r.digit_metres      <= show_digits ? dig_m : 4'd0;
    res4_r.digit_decimetres  <= show_digits ? dig_d : 4'd0;
    res4_r.digit_centimetres <= show_digits ? dig_c : 4'd0;
  end

  // result queue, space reserved by credits at issue
  uer_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (v4_r),
    .wr_data (res4_r),
    .rd_en   (pop_ok),
    .rd_data (out_res),
    .full    (),
    .empty   (out_empty)
  );

endmodule

### hdl/ultrasonic_echo_ranger_core.sv
// top level of the ultrasonic echo ranger: register port, front end, tick queue, back end
// The core takes one timer tick beat per clock cycle (push while full is low) and returns one
// result beat per tick in order: the trigger level for that tick and, on the tick the echo
// falls, the distance floor(ticks*17/1000) in cm with its three decimal digits and a range
// flag. The phase sequencer in the front end steps once per accepted tick, so a beat can be
// pushed every cycle; the back end is a pipeline (scale, reciprocal multiply, correct and
// range check, digit split, queue write), and a result reaches the out_ ports through the
// tick queue, that pipeline and the result queue. full rises only when the result queue is
// popped more slowly than ticks are pushed and the tick queue has filled behind it. Write the
// registers over the APB port at byte addresses 0 (trigger_ticks), 4 (gap_ticks) and 8
// (max_range_cm) only while no beats are in flight; the core does not enforce this.
module ultrasonic_echo_ranger_core #(
  parameter int COUNTER_BITS = 16,
  parameter int MID_DEPTH    = 4,
  parameter int OUT_DEPTH    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // tick input
  input  logic                       push,
  output logic                       full,
  input  logic                       in_echo,
  // results
  input  logic                       pop,
  output logic                       empty,
  output logic                       out_trigger,
  output logic                       out_done_res,
  output logic                       out_out_of_range,
  output logic [10:0]                out_distance_cm,
  output logic [15:0]                out_pulse_ticks,
  output logic [3:0]                 out_digit_metres,
  output logic [3:0]                 out_digit_decimetres,
  output logic [3:0]                 out_digit_centimetres,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::REG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import uer_pkg::*;

  localparam int TW = $bits(tick_flags_t) + COUNTER_BITS;

  logic [7:0]              trigger_ticks_r;
  logic [19:0]             gap_ticks_r;
  logic [10:0]             max_range_r;
  logic                    reg_wr;

  logic                    accept;
  tick_flags_t             fe_flags, be_flags;
  logic [COUNTER_BITS-1:0] fe_pulse, be_pulse;
  logic [TW-1:0]           mid_rd_data;
  logic                    mid_empty, mid_rd;
  result_t                 res;

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      gap_ticks_r     <= GAP_TICKS_RST;
      max_range_r     <= MAX_RANGE_RST;
    end else if (reg_wr) begin
      unique case (paddr[3:2])
        REG_TRIGGER_TICKS: trigger_ticks_r <= pwdata[7:0];
        REG_GAP_TICKS:     gap_ticks_r     <= pwdata[19:0];
        REG_MAX_RANGE:     max_range_r     <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_TRIGGER_TICKS: prdata = {24'd0, trigger_ticks_r};
      REG_GAP_TICKS:     prdata = {12'd0, gap_ticks_r};
      REG_MAX_RANGE:     prdata = {21'd0, max_range_r};
      default:           prdata = '0;
    endcase
  end

  assign accept = push & ~full;

  uer_front #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .echo          (in_echo),
    .trigger_ticks (trigger_ticks_r),
    .gap_ticks     (gap_ticks_r),
    .tick_flags    (fe_flags),
    .tick_pulse    (fe_pulse)
  );

  // classified ticks between front and back end
  uer_queue #(
    .WIDTH (TW),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data ({fe_flags, fe_pulse}),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_data),
    .full    (full),
    .empty   (mid_empty)
  );

  assign be_flags = mid_rd_data[TW-1:COUNTER_BITS];
  assign be_pulse = mid_rd_data[COUNTER_BITS-1:0];

  uer_back #(
    .COUNTER_BITS (COUNTER_BITS),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (~mid_empty),
    .tick_ready   (mid_rd),
    .tick_flags   (be_flags),
    .tick_pulse   (be_pulse),
    .max_range_cm (max_range_r),
    .out_pop      (pop),
    .out_empty    (empty),
    .out_res      (res)
  );

  assign out_trigger           = res.trigger;
  assign out_done_res          = res.done_res;
  assign out_out_of_range      = res.out_of_range;
  assign out_distance_cm       = res.distance_cm;
  assign out_pulse_ticks       = res.pulse_ticks;
  assign out_digit_metres      = res.digit_metres;
  assign out_digit_decimetres  = res.digit_decimetres;
  assign out_digit_centimetres = res.digit_centimetres;

endmodule

### bench/tb_ultrasonic_echo_ranger_core.sv
// self-checking bench for the ultrasonic echo ranger core: tick beats in, one result beat per tick
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_core;
  import uer_pkg::*;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                push    = 1'b0;
  logic                full;
  logic                in_echo = 1'b0;
  logic                pop     = 1'b0;
  logic                empty;
  logic                out_trigger;
  logic                out_done_res;
  logic                out_out_of_range;
  logic [10:0]         out_distance_cm;
  logic [15:0]         out_pulse_ticks;
  logic [3:0]          out_digit_metres;
  logic [3:0]          out_digit_decimetres;
  logic [3:0]          out_digit_centimetres;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [REG_AW-1:0]   paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  ultrasonic_echo_ranger_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_echo               (in_echo),
    .pop                   (pop),
    .empty                 (empty),
    .out_trigger           (out_trigger),
    .out_done_res          (out_done_res),
    .out_out_of_range      (out_out_of_range),
    .out_distance_cm       (out_distance_cm),
    .out_pulse_ticks       (out_pulse_ticks),
    .out_digit_metres      (out_digit_metres),
    .out_digit_decimetres  (out_digit_decimetres),
    .out_digit_centimetres (out_digit_centimetres),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // echo levels waiting to be sent, and the result beats they will cause
  bit      echo_backlog[$];
  result_t ranging_due[$];

  int fail_count  = 0;
  int ticks_fed   = 0;
  int pings_seen  = 0;
  int oor_seen    = 0;
  int writes_done = 0;

  // register copies and sequencer state of the ranger
  logic [7:0]  cfg_trig      = TRIGGER_TICKS_RST;
  logic [19:0] cfg_gap       = GAP_TICKS_RST;
  logic [10:0] cfg_max_range = MAX_RANGE_RST;
  phase_t      echo_phase    = PH_TRIGGER;
  logic [15:0] pulse_len     = '0;
  logic        pulse_wrapped = 1'b0;
  logic [19:0] phase_ticks   = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one more echo-high tick, wrapping counter flags overflow
  function automatic void bump_pulse();
    pulse_len = pulse_len + 16'd1;
    if (pulse_len == 16'd0) pulse_wrapped = 1'b1;
  endfunction

  // advance the ranger by one tick and return the result beat it gives
  function automatic result_t range_tick(input logic echo);
    result_t     res;
    logic [19:0] trig_len;
    int unsigned scaled;
    logic [10:0] dist_cm;
    logic        oor;
    res = '0;
    case (echo_phase)
      PH_TRIGGER: begin
        trig_len = (cfg_trig == 8'd0) ? 20'd1 : 20'(cfg_trig);
        res.trigger = 1'b1;
        phase_ticks = phase_ticks + 20'd1;
        if (phase_ticks >= trig_len) begin
          phase_ticks = '0;
          echo_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // the tick the echo is first seen high already counts
        if (echo) begin
          bump_pulse();
          echo_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          bump_pulse();
        end else begin
          scaled = (32'(pulse_len) * 32'd17) / 32'd1000;
          dist_cm = (scaled > 32'd2047) ? 11'd2047 : 11'(scaled);
          oor = pulse_wrapped || (dist_cm >= cfg_max_range);
          res.done_res = 1'b1;
          res.out_of_range = oor;
          res.distance_cm = dist_cm;
          res.pulse_ticks = pulse_len;
          if (!oor) begin
            res.digit_metres = 4'((dist_cm % 1000) / 100);
            res.digit_decimetres = 4'((dist_cm % 100) / 10);
            res.digit_centimetres = 4'(dist_cm % 10);
          end
          pulse_len = '0;
          pulse_wrapped = 1'b0;
          phase_ticks = '0;
          echo_phase = (cfg_gap == 20'd0) ? PH_TRIGGER : PH_GAP;
        end
      end
      default: begin
        phase_ticks = phase_ticks + 20'd1;
        if (phase_ticks >= cfg_gap) begin
          phase_ticks = '0;
          echo_phase = PH_TRIGGER;
        end
      end
    endcase
    return res;
  endfunction

  // ticks after a falling echo during which the echo is ignored
  function automatic int dead_ticks();
    return int'(cfg_gap) + ((cfg_trig == 8'd0) ? 1 : int'(cfg_trig));
  endfunction

  function automatic void queue_level(input int n, input bit lvl);
    repeat (n) echo_backlog.push_back(lvl);
  endfunction

  // one echo pulse, its fall, the ignored stretch (optionally noisy) and a wait
  function automatic void queue_ping(input int high_n, input int wait_n, input bit noisy);
    int dead;
    dead = dead_ticks();
    queue_level(high_n, 1'b1);
    echo_backlog.push_back(1'b0);
    for (int k = 0; k < dead; k++) echo_backlog.push_back(noisy ? 1'($urandom) : 1'b0);
    queue_level(wait_n, 1'b0);
  endfunction

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endfunction

  // register write: setup beat then access beat, model updated on completion
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIGGER_TICKS: cfg_trig = val[7:0];
      REG_GAP_TICKS:     cfg_gap = val[19:0];
      REG_MAX_RANGE:     cfg_max_range = val[10:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // wait until every tick is sent and answered, then let the pipeline settle
  task automatic drain_ticks();
    while (echo_backlog.size() != 0 || push || ranging_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // random settings, then well-formed pings with noise in the ignored stretches
  task automatic run_round(input int target);
    int trig;
    int gap;
    int maxr;
    int start_sz;
    case ($urandom_range(0, 9))
      0:       trig = 0;
      1:       trig = 255;
      2:       trig = 1;
      default: trig = $urandom_range(2, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       gap = 0;
      1:       gap = 1;
      2:       gap = $urandom_range(100, 400);
      default: gap = $urandom_range(2, 16);
    endcase
    case ($urandom_range(0, 9))
      0:       maxr = 0;
      1:       maxr = 1;
      2:       maxr = 1114;
      3:       maxr = 2047;
      4:       maxr = $urandom_range(0, 2047);
      default: maxr = $urandom_range(1, 12);
    endcase
    // unused upper bits carry junk, which the registers must drop
    cfg_write(REG_TRIGGER_TICKS, {24'($urandom), 8'(trig)});
    cfg_write(REG_GAP_TICKS, {12'($urandom), 20'(gap)});
    cfg_write(REG_MAX_RANGE, {21'($urandom), 11'(maxr)});
    start_sz = echo_backlog.size();
    queue_level(dead_ticks() + 2, 1'b0);
    while (echo_backlog.size() - start_sz < target) begin
      queue_ping(($urandom_range(0, 7) == 0) ? $urandom_range(60, 1500) : $urandom_range(1, 70),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4),
                 $urandom_range(0, 3) != 0);
    end
    drain_ticks();
  endtask

  // sender: bursts of tick beats with random gaps, prediction on acceptance
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push       <= 1'b0;
      in_echo    <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (push && !full) begin
        ranging_due.push_back(range_tick(in_echo));
        ticks_fed++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          push     <= 1'b0;
        end else if (echo_backlog.size() != 0) begin
          push    <= 1'b1;
          in_echo <= echo_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 64);
            gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating pop pattern, reloaded when the six-bit age counter reaches 63, checks each result beat
  logic [15:0] pop_pattern = 16'hFFFF;
  logic [5:0]  pattern_age = '0;

  always @(posedge clk) begin : receiver
    logic [15:0] nxt_pattern;
    result_t     want;
    if (!rst_n) begin
      pop         <= 1'b0;
      pop_pattern <= 16'hFFFF;
      pattern_age <= '0;
    end else begin
      if (pop && !empty) begin
        if (ranging_due.size() == 0) begin
          $error("result beat with no tick awaiting it");
          fail_count++;
        end else begin
          want = ranging_due.pop_front();
          check_field("trigger", 16'(want.trigger), 16'(out_trigger));
          check_field("done_res", 16'(want.done_res), 16'(out_done_res));
          check_field("out_of_range", 16'(want.out_of_range), 16'(out_out_of_range));
          check_field("distance_cm", 16'(want.distance_cm), 16'(out_distance_cm));
          check_field("pulse_ticks", want.pulse_ticks, out_pulse_ticks);
          check_field("digit_metres", 16'(want.digit_metres), 16'(out_digit_metres));
          check_field("digit_decimetres", 16'(want.digit_decimetres),
                      16'(out_digit_decimetres));
          check_field("digit_centimetres", 16'(want.digit_centimetres),
                      16'(out_digit_centimetres));
        end
        if (out_done_res === 1'b1) pings_seen++;
        if (out_done_res === 1'b1 && out_out_of_range === 1'b1) oor_seen++;
      end
      if (pattern_age == 6'd63) begin
        case ($urandom_range(0, 3))
          0, 1:    nxt_pattern = 16'hFFFF;
          2:       nxt_pattern = 16'($urandom) | 16'h5555;
          default: nxt_pattern = 16'h00FF;
        endcase
      end else begin
        nxt_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
      pop_pattern <= nxt_pattern;
      pattern_age <= pattern_age + 6'd1;
      pop         <= nxt_pattern[0];
    end
  end

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one short ping, leaving the block deep in a long gap
    queue_level(30, 1'b0);
    queue_level(100, 1'b1);
    queue_level(6, 1'b0);
    drain_ticks();

    // widest settings, then the gap lowered below the time already spent in it;
    // the echo then stays low, so the block is left waiting for it
    cfg_write(REG_TRIGGER_TICKS, 32'd255);
    cfg_write(REG_GAP_TICKS, 32'd1048575);
    cfg_write(REG_MAX_RANGE, 32'd2047);
    cfg_write(REG_GAP_TICKS, 32'd2);
    queue_level(dead_ticks() + 3, 1'b0);
    drain_ticks();

    // zero trigger length, zero gap, smallest range
    cfg_write(REG_TRIGGER_TICKS, 32'd0);
    cfg_write(REG_GAP_TICKS, 32'd0);
    cfg_write(REG_MAX_RANGE, 32'd1);
    queue_level(dead_ticks() + 3, 1'b0);
    queue_ping(1, 1, 1'b1);
    queue_ping(58, 0, 1'b1);
    queue_ping(59, 0, 1'b1);
    drain_ticks();

    // range limit boundary one step higher
    cfg_write(REG_MAX_RANGE, 32'd2);
    queue_level(dead_ticks() + 3, 1'b0);
    queue_ping(117, 3, 1'b1);
    queue_ping(118, 3, 1'b1);
    drain_ticks();

    // random part, several register settings
    repeat (3) run_round(100);

    repeat (20) @(posedge clk);
    $display("ranger run: %0d tick beats, %0d echo measurements (%0d out of range), %0d writes",
             ticks_fed, pings_seen, oor_seen, writes_done);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
hdl/uer_pkg.sv
hdl/uer_queue.sv
hdl/uer_front.sv
hdl/uer_back.sv
hdl/ultrasonic_echo_ranger_core.sv
bench/tb_ultrasonic_echo_ranger_core.sv
